### hw/rtl/rtcldt_pkg.sv
// Shared types, constants and calendar helpers for the local date/time block.
// Used by every module under hw/rtl; depends on nothing else.
package rtcldt_pkg;

	localparam int CUR_W = 23;

	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [16:0] LAST_SECOND = 17'd86399;
	localparam logic [31:0] MS_PER_DAY = 32'd86400000;
	localparam logic [CUR_W-1:0] SECS_PER_DAY_W = CUR_W'(86400);
	localparam logic signed [20:0] SECS_PER_DAY_S = 21'sd86400;
	localparam logic signed [20:0] LAST_SECOND_S = 21'sd86399;
	localparam logic signed [20:0] JST_SHIFT_SECS = 21'sd32400;
	localparam logic signed [11:0] DST_MINUTES = 12'sd60;

	// Reciprocals for exact division by constants (checked over the full input range).
	// x / 1000 = ((x >> 3) * RECIP_125) >> 35 for any 32-bit x.
	localparam logic [28:0] RECIP_125 = 29'd274877907;
	// x / 60 = ((x >> 2) * RECIP_15_WIDE) >> 26 for any 23-bit x.
	localparam logic [22:0] RECIP_15_WIDE = 23'd4473925;
	// x / 60 = ((x >> 2) * RECIP_15_NARROW) >> 19 for any 17-bit x.
	localparam logic [15:0] RECIP_15_NARROW = 16'd34953;

	localparam logic [16:0] MINUTES_PER_DAY = 17'd1440;
	localparam logic [4:0] LAST_HOUR = 5'd23;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		CFG_ZONE_OFFSET = 1'b0,
		CFG_DAYLIGHT    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
	} date_t;

	localparam date_t DATE_EPOCH = '{day: 5'd1, month: 4'd1, year: 8'd0};

	// Decoded clock reading, ready to be written into the time-keeping state.
	typedef struct packed {
		logic        err;
		logic [16:0] base;
		date_t       date;
	} load_t;

	// Time of day (may run past one day on long gaps) and date of one result.
	typedef struct packed {
		logic [CUR_W-1:0] cur;
		date_t            date;
		logic             err;
	} stamp_t;

	// Nibbles are taken as they come, so a bad digit decodes up to 165.
	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		return (8'(b[7:4]) * 8'd10) + 8'(b[3:0]);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [7:0] y);
		logic [3:0] idx;
		idx = m - 4'd1;
		if (m < 4'd1 || m > 4'd12) begin
			return 5'd31;
		end else if (m == 4'd2 && y[1:0] == 2'b00) begin
			return 5'd29;
		end else begin
			return MONTH_LEN[idx];
		end
	endfunction

	function automatic date_t step_back(input date_t d);
		date_t r;
		r = d;
		r.day = d.day - 5'd1;
		if (r.day == 5'd0) begin
			r.month = d.month - 4'd1;
			if (r.month == 4'd0) begin
				r.year = d.year - 8'd1;
				r.month = 4'd12;
			end
			r.day = days_in_month(r.month, r.year);
		end
		return r;
	endfunction

	function automatic date_t step_forward(input date_t d);
		date_t      r;
		logic [5:0] nd;
		logic [4:0] nm;
		r = d;
		nd = {1'b0, d.day} + 6'd1;
		nm = {1'b0, d.month} + 5'd1;
		if (nd > {1'b0, days_in_month(d.month, d.year)}) begin
			r.day = 5'd1;
			if (nm > 5'd12) begin
				r.month = 4'd1;
				r.year = d.year + 8'd1;
			end else begin
				r.month = nm[3:0];
			end
		end else begin
			r.day = nd[4:0];
		end
		return r;
	endfunction

	function automatic logic [CUR_W-1:0] div1000(input logic [31:0] x);
		logic [57:0] p;
		p = 58'(x[31:3]) * 58'(RECIP_125);
		return p[57:35];
	endfunction

endpackage

### hw/rtl/rtcldt_load.sv
// Decodes a BCD clock reading in Japan time into local seconds of day and date.
// Depends on rtcldt_pkg for the calendar helpers and constants.
module rtcldt_load import rtcldt_pkg::*; (
	input  logic              [7:0]  clock_status,
	input  logic              [7:0]  bcd_hour,
	input  logic              [7:0]  bcd_minute,
	input  logic              [7:0]  bcd_second,
	input  logic              [7:0]  bcd_day,
	input  logic              [7:0]  bcd_month,
	input  logic              [7:0]  bcd_year,
	input  logic signed       [10:0] zone_offset_minutes,
	input  logic                     daylight_saving,
	output load_t                    load
);

	logic              [7:0]  h, m, s, yr;
	logic              [7:0]  dv, mv;
	logic              [19:0] hms;
	logic signed       [11:0] ofs;
	logic signed       [20:0] ofs_secs;
	logic signed       [20:0] t, t2;
	date_t                    date0, date1;

	always_comb begin
		h = bcd_value(bcd_hour);
		m = bcd_value(bcd_minute);
		s = bcd_value(bcd_second);
		dv = bcd_value(bcd_day);
		mv = bcd_value(bcd_month);
		yr = bcd_value(bcd_year);
		hms = (20'(h) * 20'd3600) + (20'(m) * 20'd60) + 20'(s);

		ofs = {zone_offset_minutes[10], zone_offset_minutes} + (daylight_saving ? DST_MINUTES : 12'sd0);
		ofs_secs = {{9{ofs[11]}}, ofs} * 21'sd60;
		t = $signed({1'b0, hms}) - JST_SHIFT_SECS + ofs_secs;

		date0 = '{day: dv[4:0], month: mv[3:0], year: yr};
		if (t < 21'sd0) begin
			date1 = step_back(date0);
			t2 = t + SECS_PER_DAY_S;
		end else if (t >= SECS_PER_DAY_S) begin
			date1 = step_forward(date0);
			t2 = t - SECS_PER_DAY_S;
		end else begin
			date1 = date0;
			t2 = t;
		end

		// A reading far outside the day only moves one day, then pins.
		if (t2 < 21'sd0) begin
			t2 = 21'sd0;
		end else if (t2 > LAST_SECOND_S) begin
			t2 = LAST_SECOND_S;
		end

		if (clock_status != 8'd0) begin
			load = '{err: 1'b1, base: 17'd0, date: DATE_EPOCH};
		end else begin
			load = '{err: 1'b0, base: t2[16:0], date: date1};
		end
	end

endmodule

### hw/rtl/rtcldt_state.sv
// Time-keeping state: stored seconds of day, date, last check and error flag.
// Depends on rtcldt_pkg; the decoded load comes from rtcldt_load.
module rtcldt_state import rtcldt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        opcode,
	input  logic [31:0] now_ms,
	input  load_t       load,
	output stamp_t      stamp
);

	logic [16:0]      base_seconds_q;
	date_t            date_q;
	logic [31:0]      last_check_ms_q;
	logic             error_flag_q;

	logic [16:0]      base_d;
	date_t            date_d;
	logic [31:0]      last_d;
	logic             err_d;

	logic [31:0]      elapsed_ms;
	logic [CUR_W-1:0] elapsed_s;
	logic [CUR_W-1:0] sum, sum_rolled;
	logic             roll;
	logic [31:0]      whole_ms;
	date_t            date_fwd;

	always_comb begin
		elapsed_ms = now_ms - last_check_ms_q;
		elapsed_s = div1000(elapsed_ms);
		sum = CUR_W'(base_seconds_q) + elapsed_s;
		roll = sum >= SECS_PER_DAY_W;
		sum_rolled = sum - SECS_PER_DAY_W;
		whole_ms = (32'(elapsed_s) << 10) - (32'(elapsed_s) << 4) - (32'(elapsed_s) << 3);
		date_fwd = step_forward(date_q);

		base_d = base_seconds_q;
		date_d = date_q;
		last_d = last_check_ms_q;
		err_d = error_flag_q;

		if (opcode == OP_LOAD) begin
			// Elapsed time is zero right after a load, so no roll can happen.
			base_d = load.base;
			date_d = load.date;
			last_d = now_ms;
			err_d = load.err;
			stamp = '{cur: CUR_W'(load.base), date: load.date, err: load.err};
		end else if (roll) begin
			date_d = date_fwd;
			if (elapsed_ms >= MS_PER_DAY) begin
				last_d = last_check_ms_q + MS_PER_DAY;
			end else begin
				base_d = sum_rolled[16:0];
				last_d = last_check_ms_q + whole_ms;
			end
			stamp = '{cur: sum_rolled, date: date_fwd, err: error_flag_q};
		end else begin
			stamp = '{cur: sum, date: date_q, err: error_flag_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seconds_q <= 17'd0;
			date_q <= DATE_EPOCH;
			last_check_ms_q <= 32'd0;
			error_flag_q <= 1'b0;
		end else if (adv) begin
			base_seconds_q <= base_d;
			date_q <= date_d;
			last_check_ms_q <= last_d;
			error_flag_q <= err_d;
		end
	end

endmodule

### hw/rtl/rtcldt_split.sv
// Splits a seconds count into hour, minute and second with a register at s3.
// Depends on rtcldt_pkg for the reciprocal constants.
module rtcldt_split import rtcldt_pkg::*; (
	input  logic             clk,
	input  logic             en_s3,
	input  logic [CUR_W-1:0] cur_s2,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second
);

	logic [43:0]      q_prod;
	logic [16:0]      q60;
	logic [CUR_W-1:0] q60_x60;
	logic [CUR_W-1:0] rem60;
	logic [16:0]      q60_s3;
	logic [5:0]       sec_s3;
	logic [30:0]      h_prod;
	logic [11:0]      h60;
	logic [16:0]      h60_x60;
	logic [16:0]      min_rem;

	always_comb begin
		q_prod = 44'(cur_s2[CUR_W-1:2]) * 44'(RECIP_15_WIDE);
		q60 = q_prod[42:26];
		q60_x60 = (CUR_W'(q60) << 6) - (CUR_W'(q60) << 2);
		rem60 = cur_s2 - q60_x60;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			q60_s3 <= q60;
			sec_s3 <= rem60[5:0];
		end
	end

	always_comb begin
		h_prod = 31'(q60_s3[16:2]) * 31'(RECIP_15_NARROW);
		h60 = h_prod[30:19];
		h60_x60 = (17'(h60) << 6) - (17'(h60) << 2);
		min_rem = q60_s3 - h60_x60;
		// Past a full day the hour pins while minute and second keep counting.
		hour = (q60_s3 >= MINUTES_PER_DAY) ? LAST_HOUR : h60[4:0];
		minute = min_rem[5:0];
		second = sec_s3;
	end

endmodule

### hw/rtl/rtc_bcd_local_date_time.sv
// Local date and time from a BCD real-time clock. A load beat carries a clock reading in
// Japan time, the clock's read status and a free-running millisecond count; the block
// converts it to the zone set by zone_offset_minutes (plus one hour when daylight_saving
// is 1), steps the date by at most one day, and keeps it. A query beat adds the whole
// seconds elapsed since the last check and rolls the date forward once when midnight has
// passed; the hour pins at 23 when queries come less than daily. Every input beat gives
// exactly one result beat, in order. The block takes one beat per cycle while out_stall
// does not hold the outputs. A beat is decoded in the input register, and the stored time
// of day and date are updated as it moves into s2; the seconds count is then split into
// hour, minute and second in s3 and s4. The rate is set by the state update, which reads
// and writes the stored time in the same cycle so the next beat sees it. A read failure
// gives 1 January 2000, midnight, with read_error set. Configuration is to be written
// only while no beat is in flight; the block itself does not enforce this.
// Depends on rtcldt_pkg, rtcldt_load, rtcldt_state and rtcldt_split.
module rtc_bcd_local_date_time import rtcldt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [10:0]        cfg_wdata,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [0:0]         opcode,
	input  logic [7:0]         clock_status,
	input  logic [7:0]         bcd_hour,
	input  logic [7:0]         bcd_minute,
	input  logic [7:0]         bcd_second,
	input  logic [7:0]         bcd_day,
	input  logic [7:0]         bcd_month,
	input  logic [7:0]         bcd_year,
	input  logic [31:0]        now_ms,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [4:0]         day,
	output logic [3:0]         month,
	output logic signed [7:0]  year,
	output logic               read_error
);

	// Configuration registers.
	logic signed [10:0] zone_offset_q;
	logic               daylight_q;

	// Input register.
	logic               valid_s1;
	logic               op_s1;
	logic [7:0]         status_s1;
	logic [7:0]         bcd_hour_s1, bcd_minute_s1, bcd_second_s1;
	logic [7:0]         bcd_day_s1, bcd_month_s1, bcd_year_s1;
	logic [31:0]        now_s1;

	// Updated time stamp, then the two split steps.
	logic               valid_s2;
	stamp_t             stamp_s2;
	logic               valid_s3;
	date_t              date_s3;
	logic               err_s3;
	logic               valid_s4;
	date_t              date_s4;
	logic               err_s4;
	logic [4:0]         hour_s4;
	logic [5:0]         minute_s4, second_s4;

	logic               ready_s1, ready_s2, ready_s3, ready_s4;
	logic               accept, move_s1, move_s2, move_s3;
	load_t              load;
	stamp_t             stamp;
	logic [4:0]         hour_c;
	logic [5:0]         minute_c, second_c;

	// Each stage frees when it is empty or its beat moves on.
	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign accept = in_valid && ready_s1;
	assign move_s1 = valid_s1 && ready_s2;
	assign move_s2 = valid_s2 && ready_s3;
	assign move_s3 = valid_s3 && ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset_q <= 11'sd0;
			daylight_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ZONE_OFFSET: zone_offset_q <= $signed(cfg_wdata);
				CFG_DAYLIGHT:    daylight_q <= cfg_wdata[0];
				default:         zone_offset_q <= zone_offset_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !ready_s2);
			valid_s2 <= move_s1 || (valid_s2 && !ready_s3);
			valid_s3 <= move_s2 || (valid_s3 && !ready_s4);
			valid_s4 <= move_s3 || (valid_s4 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= opcode[0];
			status_s1 <= clock_status;
			bcd_hour_s1 <= bcd_hour;
			bcd_minute_s1 <= bcd_minute;
			bcd_second_s1 <= bcd_second;
			bcd_day_s1 <= bcd_day;
			bcd_month_s1 <= bcd_month;
			bcd_year_s1 <= bcd_year;
			now_s1 <= now_ms;
		end
		if (move_s1) begin
			stamp_s2 <= stamp;
		end
		if (move_s2) begin
			date_s3 <= stamp_s2.date;
			err_s3 <= stamp_s2.err;
		end
		if (move_s3) begin
			date_s4 <= date_s3;
			err_s4 <= err_s3;
			hour_s4 <= hour_c;
			minute_s4 <= minute_c;
			second_s4 <= second_c;
		end
	end

	rtcldt_load u_load (
		.clock_status        (status_s1),
		.bcd_hour            (bcd_hour_s1),
		.bcd_minute          (bcd_minute_s1),
		.bcd_second          (bcd_second_s1),
		.bcd_day             (bcd_day_s1),
		.bcd_month           (bcd_month_s1),
		.bcd_year            (bcd_year_s1),
		.zone_offset_minutes (zone_offset_q),
		.daylight_saving     (daylight_q),
		.load                (load)
	);

	// The stored state advances only when the beat in s1 moves into s2.
	rtcldt_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (move_s1),
		.opcode (op_s1),
		.now_ms (now_s1),
		.load   (load),
		.stamp  (stamp)
	);

	rtcldt_split u_split (
		.clk    (clk),
		.en_s3  (move_s2),
		.cur_s2 (stamp_s2.cur),
		.hour   (hour_c),
		.minute (minute_c),
		.second (second_c)
	);

	assign out_valid = valid_s4;
	assign hour = hour_s4;
	assign minute = minute_s4;
	assign second = second_s4;
	assign day = date_s4.day;
	assign month = date_s4.month;
	assign year = $signed(date_s4.year);
	assign read_error = err_s4;

	// The reciprocal division steps must always leave a proper clock reading.
	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour <= LAST_HOUR && minute < 6'd60 && second < 6'd60))
		else $error("result time fields out of range");

	// A beat held in the input register is neither dropped nor has its time count or opcode altered.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(now_s1) && $stable(op_s1)))
		else $error("input register lost or changed a held beat");

	// The state is written only for a beat that actually leaves the input register.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !valid_s2 || $past(valid_s2))
		else $error("time stamp stage filled without an input beat");

endmodule
